// ===== hw/rtl/qrm_pkg.sv =====
// ----------------------------------------------------------------------------
// qrm_pkg
// Shared types and constants for the quaternion to rotation matrix unit.
// ----------------------------------------------------------------------------
package qrm_pkg;

  localparam int NumEntries = 9;
  localparam int NumW       = 49;   // rounded dividend 2|n| + l
  localparam int DenW       = 35;   // divisor 2l
  localparam int SumW       = 35;   // signed sums of products
  localparam int QuoW       = 15;   // quotient magnitude, at most 16384
  localparam int CntW       = 4;

  localparam logic [CntW-1:0]  LastStep = CntW'(QuoW - 1);
  localparam logic signed [15:0] QOne   = 16'sd16384;

  typedef struct packed {
    logic [NumEntries-1:0][NumW-1:0] num;
    logic [NumEntries-1:0]           neg;
    logic [DenW-1:0]                 den;
    logic                            zero;
  } qrm_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_DONE
  } qrm_state_t;

endpackage

// ===== hw/rtl/qrm_front.sv =====
// ----------------------------------------------------------------------------
// qrm_front
// Four-stage pipeline: register input, form products, form sums, form the
// rounded dividends and divisor for each matrix entry.
// ----------------------------------------------------------------------------
module qrm_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic signed [15:0]  qw,
  input  logic signed [15:0]  qx,
  input  logic signed [15:0]  qy,
  input  logic signed [15:0]  qz,
  output logic                push,
  input  logic                q_full,
  output qrm_pkg::qrm_item_t  item
);

  logic adv;
  logic v1, v2, v3, v4;
  logic signed [15:0] w1, x1, y1, z1;
  logic signed [31:0] ww, xx, yy, zz, xy, xz, yz, wx, wy, wz;
  logic signed [qrm_pkg::SumW-1:0] s3 [qrm_pkg::NumEntries];
  logic signed [qrm_pkg::SumW-1:0] l3;
  qrm_pkg::qrm_item_t item4;
  qrm_pkg::qrm_item_t item4_next;

  // whole pipeline holds when the last stage cannot transfer
  assign adv      = !(v4 && q_full);
  assign in_stall = !adv;
  assign push     = v4 && !q_full;
  assign item     = item4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      w1 <= qw;
      x1 <= qx;
      y1 <= qy;
      z1 <= qz;
      ww <= w1 * w1;
      xx <= x1 * x1;
      yy <= y1 * y1;
      zz <= z1 * z1;
      xy <= x1 * y1;
      xz <= x1 * z1;
      yz <= y1 * z1;
      wx <= w1 * x1;
      wy <= w1 * y1;
      wz <= w1 * z1;
      l3    <= 35'(ww) + 35'(xx) + 35'(yy) + 35'(zz);
      s3[0] <= 35'(ww) + 35'(xx) - 35'(yy) - 35'(zz);
      s3[1] <= 35'(xy) - 35'(wz);
      s3[2] <= 35'(xz) + 35'(wy);
      s3[3] <= 35'(xy) + 35'(wz);
      s3[4] <= 35'(ww) - 35'(xx) + 35'(yy) - 35'(zz);
      s3[5] <= 35'(yz) - 35'(wx);
      s3[6] <= 35'(xz) - 35'(wy);
      s3[7] <= 35'(yz) + 35'(wx);
      s3[8] <= 35'(ww) - 35'(xx) - 35'(yy) + 35'(zz);
      item4 <= item4_next;
    end
  end

  always_comb begin
    logic [qrm_pkg::SumW-1:0] mag;
    logic [qrm_pkg::NumW-1:0] lw;
    lw = qrm_pkg::NumW'(unsigned'(l3));
    item4_next.den  = {l3[qrm_pkg::DenW-2:0], 1'b0};
    item4_next.zero = (l3 == '0);
    for (int i = 0; i < qrm_pkg::NumEntries; i++) begin
      item4_next.neg[i] = s3[i][qrm_pkg::SumW-1];
      mag = s3[i][qrm_pkg::SumW-1] ? unsigned'(-s3[i]) : unsigned'(s3[i]);
      // diagonal entries carry 16384, the others 32768; both doubled for rounding
      if (i == 0 || i == 4 || i == 8) begin
        item4_next.num[i] = (qrm_pkg::NumW'(mag) << 15) + lw;
      end else begin
        item4_next.num[i] = (qrm_pkg::NumW'(mag) << 16) + lw;
      end
    end
  end

endmodule

// ===== hw/rtl/qrm_queue.sv =====
// ----------------------------------------------------------------------------
// qrm_queue
// Two-entry queue of prepared items between front and back.
// ----------------------------------------------------------------------------
module qrm_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  qrm_pkg::qrm_item_t push_item,
  output logic               full,
  input  logic               pop,
  output logic               empty,
  output qrm_pkg::qrm_item_t pop_item
);

  qrm_pkg::qrm_item_t slot [2];
  logic       wptr, rptr;
  logic [1:0] cnt;

  assign full     = (cnt == 2'd2);
  assign empty    = (cnt == 2'd0);
  assign pop_item = slot[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      cnt  <= 2'd0;
    end else begin
      if (push) wptr <= !wptr;
      if (pop)  rptr <= !rptr;
      if (push && !pop)      cnt <= cnt + 2'd1;
      else if (pop && !push) cnt <= cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot[wptr] <= push_item;
  end

endmodule

// ===== hw/rtl/qrm_back.sv =====
// ----------------------------------------------------------------------------
// qrm_back
// Nine-lane restoring divider, one quotient bit per cycle, plus the
// output register.
// ----------------------------------------------------------------------------
module qrm_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                empty,
  output logic                pop,
  input  qrm_pkg::qrm_item_t  item,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [8:0][15:0]    res,
  output logic                zero_norm
);

  qrm_pkg::qrm_state_t state, state_next;
  logic load;
  logic [qrm_pkg::NumW-1:0]  rem [qrm_pkg::NumEntries];
  logic [qrm_pkg::QuoW-1:0]  quo [qrm_pkg::NumEntries];
  logic [qrm_pkg::NumEntries-1:0] neg;
  logic [qrm_pkg::NumEntries-1:0] ge;
  logic [qrm_pkg::NumW-1:0]  dsh;
  logic [qrm_pkg::CntW-1:0]  cnt;
  logic                      zero;

  always_ff @(posedge clk) begin
    if (rst) state <= qrm_pkg::ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    pop  = 1'b0;
    load = 1'b0;
    unique case (state)
      qrm_pkg::ST_IDLE: begin
        if (!empty) begin
          pop        = 1'b1;
          state_next = qrm_pkg::ST_DIV;
        end
      end
      qrm_pkg::ST_DIV: begin
        if (cnt == '0) state_next = qrm_pkg::ST_DONE;
      end
      qrm_pkg::ST_DONE: begin
        if (!out_valid || !out_stall) begin
          load       = 1'b1;
          state_next = qrm_pkg::ST_IDLE;
        end
      end
      default: state_next = qrm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    for (int i = 0; i < qrm_pkg::NumEntries; i++) ge[i] = (rem[i] >= dsh);
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      for (int i = 0; i < qrm_pkg::NumEntries; i++) begin
        rem[i] <= item.num[i];
        quo[i] <= '0;
      end
      neg  <= item.neg;
      dsh  <= {item.den, 14'b0};
      zero <= item.zero;
      cnt  <= qrm_pkg::LastStep;
    end else if (state == qrm_pkg::ST_DIV) begin
      for (int i = 0; i < qrm_pkg::NumEntries; i++) begin
        if (ge[i]) rem[i] <= rem[i] - dsh;
        quo[i] <= {quo[i][qrm_pkg::QuoW-2:0], ge[i]};
      end
      dsh <= dsh >> 1;
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      zero_norm <= zero;
      for (int i = 0; i < qrm_pkg::NumEntries; i++) begin
        if (zero) begin
          res[i] <= (i == 0 || i == 4 || i == 8) ? qrm_pkg::QOne : 16'sd0;
        end else if (neg[i]) begin
          res[i] <= -{1'b0, quo[i]};
        end else begin
          res[i] <= {1'b0, quo[i]};
        end
      end
    end
  end

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    pop |-> (state == qrm_pkg::ST_IDLE) && !empty)
    else $error("pop outside idle");
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    (state == qrm_pkg::ST_DIV) |-> (cnt <= qrm_pkg::LastStep))
    else $error("divider step count out of range");
  a_div_leaves: assert property (@(posedge clk) disable iff (rst)
    (state == qrm_pkg::ST_DIV) && (cnt == '0) |=> (state == qrm_pkg::ST_DONE))
    else $error("divider did not finish");
  a_identity: assert property (@(posedge clk) disable iff (rst)
    out_valid && zero_norm |-> (res[0] == qrm_pkg::QOne) && (res[1] == '0))
    else $error("zero norm without identity");

endmodule

// ===== hw/rtl/quaternion_to_rotation_matrix_unit.sv =====
// ----------------------------------------------------------------------------
// quaternion_to_rotation_matrix_unit
// Converts a quaternion (qw, qx, qy, qz) of any scale into the nine Q1.14
// entries of its 3x3 rotation matrix, dividing by the squared norm.
//
// Input channel: in_valid / in_stall with qw..qz; a transfer happens when
// in_valid is high and in_stall low. Output channel: out_valid / out_stall
// with r00..r22 and zero_norm, held steady while stalled.
// The item rate is set by the shared nine-lane restoring divider (15
// quotient steps plus load and writeback), which takes a new item from
// the queue only after the last one is written to the output register.
// The four-stage front and a two-entry queue keep taking items while the
// divider works; in_stall rises when the queue is full and the last front
// stage holds an item.
// A zero quaternion gives the identity matrix with zero_norm set.
// Reset (rst, synchronous) empties the pipeline, queue and output register.
// When the receiver stalls, the result holds, the divider finishes and waits,
// then the queue and front fill and in_stall is raised.
// ----------------------------------------------------------------------------
module quaternion_to_rotation_matrix_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] qw,
  input  logic signed [15:0] qx,
  input  logic signed [15:0] qy,
  input  logic signed [15:0] qz,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] r00,
  output logic signed [15:0] r01,
  output logic signed [15:0] r02,
  output logic signed [15:0] r10,
  output logic signed [15:0] r11,
  output logic signed [15:0] r12,
  output logic signed [15:0] r20,
  output logic signed [15:0] r21,
  output logic signed [15:0] r22,
  output logic               zero_norm
);

  logic push, q_full, pop, q_empty;
  qrm_pkg::qrm_item_t push_item, pop_item;
  logic [8:0][15:0] res;

  qrm_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .qw       (qw),
    .qx       (qx),
    .qy       (qy),
    .qz       (qz),
    .push     (push),
    .q_full   (q_full),
    .item     (push_item)
  );

  qrm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .empty     (q_empty),
    .pop_item  (pop_item)
  );

  qrm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .empty     (q_empty),
    .pop       (pop),
    .item      (pop_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res       (res),
    .zero_norm (zero_norm)
  );

  assign r00 = res[0];
  assign r01 = res[1];
  assign r02 = res[2];
  assign r10 = res[3];
  assign r11 = res[4];
  assign r12 = res[5];
  assign r20 = res[6];
  assign r21 = res[7];
  assign r22 = res[8];

endmodule
